// ----- hw/rtl/cer_pkg.sv -----
// Shared types and constants of the consensus election role machine.
package cer_pkg;

  localparam int unsigned TERM_W   = 32;
  localparam int unsigned LSN_W    = 33;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned LEAD_W   = 5;
  localparam int unsigned VOTE_W   = 5;
  localparam int unsigned ROUND_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [LEAD_W-1:0]  LEADER_NONE = 5'd16;
  localparam logic [ROUND_W-1:0] ROUND_CAP   = 3'd5;

  localparam logic [1:0] KIND_VOTE   = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [1:0] CODE_ELECTION  = 2'd0;
  localparam logic [1:0] CODE_FOLLOWER  = 2'd1;
  localparam logic [1:0] CODE_LEADER    = 2'd2;
  localparam logic [1:0] CODE_CANDIDATE = 2'd3;

  localparam logic [1:0] NOTIFY_NOBODY = 2'd0;
  localparam logic [1:0] NOTIFY_SENDER = 2'd1;
  localparam logic [1:0] NOTIFY_ALL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUORUM     = 2'd2;

  typedef enum logic [3:0] {
    ROLE_ELECTION  = 4'b0001,
    ROLE_FOLLOWER  = 4'b0010,
    ROLE_LEADER    = 4'b0100,
    ROLE_CANDIDATE = 4'b1000
  } role_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [ID_W-1:0]         from_id;
    logic [LEAD_W-1:0]       msg_leader;
    logic [TERM_W-1:0]       msg_term;
    logic signed [LSN_W-1:0] msg_commit_lsn;
    logic signed [LSN_W-1:0] msg_commit_term;
    logic signed [LSN_W-1:0] own_commit_lsn;
    logic signed [LSN_W-1:0] own_commit_term;
    logic                    heartbeat_missed;
  } item_t;

  typedef struct packed {
    logic [1:0]         role;
    logic [TERM_W-1:0]  cur_term;
    logic [LEAD_W-1:0]  cur_leader;
    logic [ROUND_W-1:0] round_count;
    logic [VOTE_W-1:0]  vote_total;
    logic [1:0]         notify;
    logic               restart_timer;
  } result_t;

endpackage

// ----- hw/rtl/cer_if.sv -----
// Channel interfaces for the event input and the result output.
interface cer_in_if;
  import cer_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [ID_W-1:0]         from_id;
  logic [LEAD_W-1:0]       msg_leader;
  logic [TERM_W-1:0]       msg_term;
  logic signed [LSN_W-1:0] msg_commit_lsn;
  logic signed [LSN_W-1:0] msg_commit_term;
  logic signed [LSN_W-1:0] own_commit_lsn;
  logic signed [LSN_W-1:0] own_commit_term;
  logic                    heartbeat_missed;

  modport source (output valid, kind, from_id, msg_leader, msg_term, msg_commit_lsn,
                  msg_commit_term, own_commit_lsn, own_commit_term, heartbeat_missed,
                  input ready);
  modport sink (input valid, kind, from_id, msg_leader, msg_term, msg_commit_lsn,
                msg_commit_term, own_commit_lsn, own_commit_term, heartbeat_missed,
                output ready);
endinterface

interface cer_out_if;
  import cer_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         role;
  logic [TERM_W-1:0]  cur_term;
  logic [LEAD_W-1:0]  cur_leader;
  logic [ROUND_W-1:0] round_count;
  logic [VOTE_W-1:0]  vote_total;
  logic [1:0]         notify;
  logic               restart_timer;

  modport source (output valid, role, cur_term, cur_leader, round_count, vote_total,
                  notify, restart_timer, input ready);
  modport sink (input valid, role, cur_term, cur_leader, round_count, vote_total,
                notify, restart_timer, output ready);
endinterface

// ----- hw/rtl/consensus_election_role_fsm.sv -----
// Role state machine of one consensus node: election, follower, leader, candidate.
//
// Usage: events (vote messages, append-entries messages and heartbeat ticks) arrive
// as beats on in_beat; every event yields exactly one result beat on out_beat that
// shows role, term, known leader, election round and vote count after the event,
// plus the vote reply target and a heartbeat timer restart flag.
// The cfg_ port writes the node's own id, the number of nodes and the quorum; it must be
// written only while no event is in flight, which the block itself does not enforce.
// Throughput: one event per cycle while the output side is not stalled. The event sits
// in an input register; once the result register is free, the role logic reads it
// with the current node state, updates the state and loads the result register in the
// same edge, so back-to-back events always see the state left by their predecessor.
// When the receiver stalls, the result register holds its beat and one more event
// can still be taken into the input register; only then does in_beat.ready drop.
// Synchronous reset (rst_n low) empties both registers and puts the node in the
// follower role with term zero, no leader, round zero and no recorded votes;
// configuration returns to self id 0, a single node and a quorum of one.
module consensus_election_role_fsm #(
  parameter int unsigned NODES     = 16,
  parameter int unsigned TERM_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cer_in_if.sink                         in_beat,
  cer_out_if.source                      out_beat,
  input  logic                           cfg_we,
  input  logic [cer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cer_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cer_pkg::*;

  // Sender ids are four bits wide, so at most sixteen nodes can ever vote.
  localparam int unsigned VMAP_BITS = (NODES < 16) ? NODES : 16;

  // Configuration registers.
  logic [ID_W-1:0]       self_id_r;
  logic [CFG_DATA_W-1:0] node_count_r;
  logic [CFG_DATA_W-1:0] quorum_r;

  // Node state.
  role_t                 role_r, role_nxt;
  logic [TERM_BITS-1:0]  term_r, term_nxt;
  logic [LEAD_W-1:0]     leader_r, leader_nxt;
  logic [ROUND_W-1:0]    round_r, round_nxt;
  logic [VMAP_BITS-1:0]  vmap_r, vmap_nxt;
  // The vote count is kept next to the bitmap so no population count is needed.
  logic [VOTE_W-1:0]     vcnt_r, vcnt_nxt;

  // Input register and result register with their valid flags.
  logic    item_valid_r;
  item_t   item_r;
  logic    res_valid_r;
  result_t res_r, res_nxt;

  logic step;

  // Decoded fields of the held event.
  logic [LEAD_W-1:0]    mlead;
  logic [TERM_BITS-1:0] mterm;
  logic [LEAD_W-1:0]    from_lead;
  logic [LEAD_W-1:0]    self_lead;
  logic                 term_lt;
  logic                 term_eq;
  logic                 lsn_ok;
  logic                 journal_wins;
  logic                 ct_higher;
  logic [VMAP_BITS-1:0] from_mask;
  logic [VMAP_BITS-1:0] self_mask;
  logic [VOTE_W-1:0]    cand_cnt;
  logic [1:0]           notify;
  logic                 restart;

  // The result register frees up when it is empty or its beat is taken now.
  assign step          = item_valid_r && (!res_valid_r || out_beat.ready);
  assign in_beat.ready = !item_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r    <= '0;
      node_count_r <= CFG_DATA_W'(1);
      quorum_r     <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELF_ID:    self_id_r    <= cfg_wdata[ID_W-1:0];
        CFG_NODE_COUNT: node_count_r <= cfg_wdata;
        CFG_QUORUM:     quorum_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_beat.ready) begin
      item_valid_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat.valid && in_beat.ready) begin
      item_r.kind             <= in_beat.kind;
      item_r.from_id          <= in_beat.from_id;
      item_r.msg_leader       <= in_beat.msg_leader;
      item_r.msg_term         <= in_beat.msg_term;
      item_r.msg_commit_lsn   <= in_beat.msg_commit_lsn;
      item_r.msg_commit_term  <= in_beat.msg_commit_term;
      item_r.own_commit_lsn   <= in_beat.own_commit_lsn;
      item_r.own_commit_term  <= in_beat.own_commit_term;
      item_r.heartbeat_missed <= in_beat.heartbeat_missed;
    end
  end

  // Comparisons shared by the role cases.
  always_comb begin
    mlead     = (item_r.msg_leader > LEADER_NONE) ? LEADER_NONE : item_r.msg_leader;
    mterm     = TERM_BITS'(item_r.msg_term);
    from_lead = LEAD_W'(item_r.from_id);
    self_lead = LEAD_W'(self_id_r);
    term_lt   = term_r < mterm;
    term_eq   = term_r == mterm;
    // A negative lsn means an empty journal, which only a higher term can beat.
    lsn_ok    = !item_r.own_commit_lsn[LSN_W-1] && !item_r.msg_commit_lsn[LSN_W-1] &&
                (item_r.own_commit_lsn[LSN_W-2:0] <= item_r.msg_commit_lsn[LSN_W-2:0]);
    journal_wins = term_lt || (term_eq && lsn_ok);
    // A negative commit term is undefined and ranks below every defined term.
    ct_higher = !item_r.msg_commit_term[LSN_W-1] &&
                (item_r.own_commit_term[LSN_W-1] ||
                 (item_r.msg_commit_term[LSN_W-2:0] > item_r.own_commit_term[LSN_W-2:0]));
    // Ids beyond the bitmap shift out and leave an empty mask.
    from_mask = VMAP_BITS'(1) << item_r.from_id;
    self_mask = VMAP_BITS'(1) << self_id_r;
    cand_cnt  = vcnt_r + VOTE_W'(|(from_mask & ~vmap_r));
  end

  // Role transitions for the held event.
  always_comb begin
    role_nxt   = role_r;
    term_nxt   = term_r;
    leader_nxt = leader_r;
    round_nxt  = round_r;
    vmap_nxt   = vmap_r;
    vcnt_nxt   = vcnt_r;
    notify     = NOTIFY_NOBODY;
    restart    = 1'b0;
    case (item_r.kind)
      KIND_VOTE: begin
        if (mlead != leader_r) begin
          case (role_r)
            ROLE_ELECTION: begin
              if (leader_r == LEADER_NONE) begin
                leader_nxt = mlead;
                term_nxt   = mterm;
                notify     = NOTIFY_SENDER;
              end
            end
            ROLE_LEADER: begin
              if (term_lt) begin
                role_nxt   = ROLE_ELECTION;
                term_nxt   = mterm;
                leader_nxt = mlead;
              end
              notify = NOTIFY_SENDER;
            end
            default: begin
              if (journal_wins) begin
                role_nxt   = ROLE_ELECTION;
                term_nxt   = mterm;
                leader_nxt = mlead;
                restart    = 1'b1;
              end
              notify = NOTIFY_SENDER;
            end
          endcase
        end else begin
          case (role_r)
            ROLE_ELECTION: begin
              term_nxt = mterm;
              notify   = NOTIFY_SENDER;
            end
            ROLE_FOLLOWER: begin
              notify = NOTIFY_SENDER;
            end
            ROLE_CANDIDATE: begin
              vmap_nxt = vmap_r | from_mask;
              vcnt_nxt = cand_cnt;
              if (cand_cnt >= quorum_r) begin
                role_nxt   = ROLE_LEADER;
                term_nxt   = term_r + TERM_BITS'(1);
                round_nxt  = '0;
                leader_nxt = self_lead;
                notify     = NOTIFY_ALL;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_APPEND: begin
        case (role_r)
          ROLE_ELECTION: begin
            if (from_lead == leader_r || (from_lead == mlead && (term_lt || term_eq))) begin
              role_nxt   = ROLE_FOLLOWER;
              term_nxt   = mterm;
              leader_nxt = mlead;
              restart    = 1'b1;
            end
          end
          ROLE_FOLLOWER: begin
            if (term_lt) begin
              leader_nxt = mlead;
              term_nxt   = mterm;
            end
          end
          ROLE_LEADER: begin
            if (term_lt || ct_higher) begin
              role_nxt   = ROLE_FOLLOWER;
              term_nxt   = mterm;
              leader_nxt = mlead;
            end
          end
          default: begin
            if ((term_lt || term_eq) && mlead == from_lead) begin
              role_nxt   = ROLE_FOLLOWER;
              round_nxt  = '0;
              term_nxt   = mterm;
              leader_nxt = mlead;
              vmap_nxt   = '0;
              vcnt_nxt   = '0;
            end
          end
        endcase
      end
      KIND_TICK: begin
        if (role_r != ROLE_LEADER && item_r.heartbeat_missed) begin
          term_nxt   = term_r + TERM_BITS'(1);
          leader_nxt = self_lead;
          case (role_r)
            ROLE_ELECTION: begin
              role_nxt  = ROLE_CANDIDATE;
              round_nxt = ROUND_W'(1);
            end
            ROLE_FOLLOWER: begin
              // A node alone in its cluster takes leadership without a vote.
              if (node_count_r <= CFG_DATA_W'(1)) begin
                role_nxt = ROLE_LEADER;
              end else begin
                role_nxt  = ROLE_CANDIDATE;
                round_nxt = ROUND_W'(1);
                vmap_nxt  = vmap_r | self_mask;
                vcnt_nxt  = vcnt_r + VOTE_W'(|(self_mask & ~vmap_r));
              end
            end
            default: begin
              // A candidate that timed out starts a fresh round with only its own vote.
              if (round_r < ROUND_CAP) begin
                round_nxt = round_r + ROUND_W'(1);
              end
              vmap_nxt = self_mask;
              vcnt_nxt = VOTE_W'(|self_mask);
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (role_nxt)
      ROLE_ELECTION:  res_nxt.role = CODE_ELECTION;
      ROLE_FOLLOWER:  res_nxt.role = CODE_FOLLOWER;
      ROLE_LEADER:    res_nxt.role = CODE_LEADER;
      ROLE_CANDIDATE: res_nxt.role = CODE_CANDIDATE;
      default:        res_nxt.role = CODE_FOLLOWER;
    endcase
    res_nxt.cur_term      = TERM_W'(term_nxt);
    res_nxt.cur_leader    = leader_nxt;
    res_nxt.round_count   = round_nxt;
    res_nxt.vote_total    = vcnt_nxt;
    res_nxt.notify        = notify;
    res_nxt.restart_timer = restart;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r   <= ROLE_FOLLOWER;
      term_r   <= '0;
      leader_r <= LEADER_NONE;
      round_r  <= '0;
      vmap_r   <= '0;
      vcnt_r   <= '0;
    end else if (step) begin
      role_r   <= role_nxt;
      term_r   <= term_nxt;
      leader_r <= leader_nxt;
      round_r  <= round_nxt;
      vmap_r   <= vmap_nxt;
      vcnt_r   <= vcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step) begin
      res_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_beat.valid         = res_valid_r;
  assign out_beat.role          = res_r.role;
  assign out_beat.cur_term      = res_r.cur_term;
  assign out_beat.cur_leader    = res_r.cur_leader;
  assign out_beat.round_count   = res_r.round_count;
  assign out_beat.vote_total    = res_r.vote_total;
  assign out_beat.notify        = res_r.notify;
  assign out_beat.restart_timer = res_r.restart_timer;

  // The kept vote count always matches the bitmap it summarizes.
  a_vote_count: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r == VOTE_W'($countones(vmap_r)))
    else $error("vote count does not match vote bitmap");

  // The election round never passes its cap.
  a_round_cap: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= ROUND_CAP)
    else $error("election round above cap");

  // The known leader is a node id or none.
  a_leader_range: assert property (@(posedge clk) disable iff (!rst_n)
    leader_r <= LEADER_NONE)
    else $error("leader id out of range");

  // The result loaded by a step reflects the state that the step left behind.
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (res_r.vote_total == vcnt_r) && (res_r.cur_term == TERM_W'(term_r)) &&
             (res_r.cur_leader == leader_r))
    else $error("result beat disagrees with node state");

  // The node state changes only when an event is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(term_r) && $stable(role_r) && $stable(vmap_r))
    else $error("node state changed without an event");

endmodule

// ----- sim/consensus_election_role_fsm_checker.sv -----
// Checker that mirrors the election role machine and compares every result beat.
`timescale 1ns / 100ps

module consensus_election_role_fsm_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  cer_in_if                              in_mon,
  cer_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [cer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cer_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatch_count,
  output int                             awaited_count
);
  import cer_pkg::*;

  // Mirrored node state and settings.
  logic [1:0]            node_role;
  logic [TERM_W-1:0]     node_term;
  logic [LEAD_W-1:0]     known_leader;
  logic [ROUND_W-1:0]    round_no;
  logic [15:0]           voters;
  logic [ID_W-1:0]       node_id;
  logic [CFG_DATA_W-1:0] cluster_nodes;
  logic [CFG_DATA_W-1:0] votes_to_win;

  result_t awaited_states[$];
  int      errs;
  int      n_checked;

  function automatic void fault(string msg);
    if (errs < 10) begin
      $display("[%0t] checker: %s", $time, msg);
    end
    errs++;
  endfunction

  // A vote request wins when its term is newer, or on an equal term when both journals
  // hold entries and ours does not reach past the sender's.
  function automatic logic journal_wins(item_t ev);
    return (node_term < ev.msg_term) ||
           (node_term == ev.msg_term && !ev.own_commit_lsn[LSN_W-1] &&
            !ev.msg_commit_lsn[LSN_W-1] && ev.own_commit_lsn <= ev.msg_commit_lsn);
  endfunction

  // Any negative commit term is undefined and ranks below every defined term.
  function automatic logic commit_newer(item_t ev);
    return !ev.msg_commit_term[LSN_W-1] &&
           (ev.own_commit_term[LSN_W-1] || ev.msg_commit_term > ev.own_commit_term);
  endfunction

  function automatic result_t role_machine_step(item_t ev);
    logic [LEAD_W-1:0] lead;
    logic [LEAD_W-1:0] sender;
    logic [1:0]        notify;
    logic              restart;
    result_t           r;
    lead    = (ev.msg_leader > LEADER_NONE) ? LEADER_NONE : ev.msg_leader;
    sender  = {1'b0, ev.from_id};
    notify  = NOTIFY_NOBODY;
    restart = 1'b0;
    case (ev.kind)
      KIND_VOTE: begin
        if (lead != known_leader) begin
          case (node_role)
            CODE_ELECTION: begin
              if (known_leader == LEADER_NONE) begin
                known_leader = lead;
                node_term    = ev.msg_term;
                notify       = NOTIFY_SENDER;
              end
            end
            CODE_LEADER: begin
              if (node_term < ev.msg_term) begin
                node_role    = CODE_ELECTION;
                node_term    = ev.msg_term;
                known_leader = lead;
              end
              notify = NOTIFY_SENDER;
            end
            default: begin
              if (journal_wins(ev)) begin
                node_role    = CODE_ELECTION;
                node_term    = ev.msg_term;
                known_leader = lead;
                restart      = 1'b1;
              end
              notify = NOTIFY_SENDER;
            end
          endcase
        end else begin
          case (node_role)
            CODE_ELECTION: begin
              node_term = ev.msg_term;
              notify    = NOTIFY_SENDER;
            end
            CODE_FOLLOWER: notify = NOTIFY_SENDER;
            CODE_CANDIDATE: begin
              voters[ev.from_id] = 1'b1;
              if ($countones(voters) >= votes_to_win) begin
                node_role    = CODE_LEADER;
                node_term    = node_term + 1'b1;
                round_no     = '0;
                known_leader = {1'b0, node_id};
                notify       = NOTIFY_ALL;
              end
            end
            default: ;
          endcase
        end
      end
      KIND_APPEND: begin
        case (node_role)
          CODE_ELECTION: begin
            if (sender == known_leader || (sender == lead && ev.msg_term >= node_term)) begin
              node_role    = CODE_FOLLOWER;
              node_term    = ev.msg_term;
              known_leader = lead;
              restart      = 1'b1;
            end
          end
          CODE_FOLLOWER: begin
            if (ev.msg_term > node_term) begin
              known_leader = lead;
              node_term    = ev.msg_term;
            end
          end
          CODE_LEADER: begin
            if (node_term < ev.msg_term || commit_newer(ev)) begin
              node_role    = CODE_FOLLOWER;
              node_term    = ev.msg_term;
              known_leader = lead;
            end
          end
          default: begin
            if (node_term <= ev.msg_term && lead == sender) begin
              node_role    = CODE_FOLLOWER;
              round_no     = '0;
              node_term    = ev.msg_term;
              known_leader = lead;
              voters       = '0;
            end
          end
        endcase
      end
      KIND_TICK: begin
        if (node_role != CODE_LEADER && ev.heartbeat_missed) begin
          node_term    = node_term + 1'b1;
          known_leader = {1'b0, node_id};
          case (node_role)
            CODE_ELECTION: begin
              node_role = CODE_CANDIDATE;
              round_no  = 3'd1;
            end
            CODE_FOLLOWER: begin
              if (cluster_nodes <= 5'd1) begin
                node_role = CODE_LEADER;
              end else begin
                node_role       = CODE_CANDIDATE;
                round_no        = 3'd1;
                voters[node_id] = 1'b1;
              end
            end
            default: begin
              if (round_no < ROUND_CAP) begin
                round_no = round_no + 1'b1;
              end
              voters          = '0;
              voters[node_id] = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
    r.role          = node_role;
    r.cur_term      = node_term;
    r.cur_leader    = known_leader;
    r.round_count   = round_no;
    r.vote_total    = VOTE_W'($countones(voters));
    r.notify        = notify;
    r.restart_timer = restart;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    item_t   ev;
    result_t want;
    result_t got;
    if (!rst_n) begin
      node_role     = CODE_FOLLOWER;
      node_term     = '0;
      known_leader  = LEADER_NONE;
      round_no      = '0;
      voters        = '0;
      node_id       = '0;
      cluster_nodes = 5'd1;
      votes_to_win  = 5'd1;
      awaited_states.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SELF_ID:    node_id       = cfg_wdata[ID_W-1:0];
          CFG_NODE_COUNT: cluster_nodes = cfg_wdata;
          CFG_QUORUM:     votes_to_win  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        ev.kind             = in_mon.kind;
        ev.from_id          = in_mon.from_id;
        ev.msg_leader       = in_mon.msg_leader;
        ev.msg_term         = in_mon.msg_term;
        ev.msg_commit_lsn   = in_mon.msg_commit_lsn;
        ev.msg_commit_term  = in_mon.msg_commit_term;
        ev.own_commit_lsn   = in_mon.own_commit_lsn;
        ev.own_commit_term  = in_mon.own_commit_term;
        ev.heartbeat_missed = in_mon.heartbeat_missed;
        awaited_states.push_back(role_machine_step(ev));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.role          = out_mon.role;
        got.cur_term      = out_mon.cur_term;
        got.cur_leader    = out_mon.cur_leader;
        got.round_count   = out_mon.round_count;
        got.vote_total    = out_mon.vote_total;
        got.notify        = out_mon.notify;
        got.restart_timer = out_mon.restart_timer;
        if (awaited_states.size() == 0) begin
          fault($sformatf("result %0d arrived with no event waiting for it", n_checked));
        end else begin
          want = awaited_states.pop_front();
          if (got.role != want.role)
            fault($sformatf("result %0d: role expected %0d, got %0d",
                            n_checked, want.role, got.role));
          if (got.cur_term != want.cur_term)
            fault($sformatf("result %0d: cur_term expected %0d, got %0d",
                            n_checked, want.cur_term, got.cur_term));
          if (got.cur_leader != want.cur_leader)
            fault($sformatf("result %0d: cur_leader expected %0d, got %0d",
                            n_checked, want.cur_leader, got.cur_leader));
          if (got.round_count != want.round_count)
            fault($sformatf("result %0d: round_count expected %0d, got %0d",
                            n_checked, want.round_count, got.round_count));
          if (got.vote_total != want.vote_total)
            fault($sformatf("result %0d: vote_total expected %0d, got %0d",
                            n_checked, want.vote_total, got.vote_total));
          if (got.notify != want.notify)
            fault($sformatf("result %0d: notify expected %0d, got %0d",
                            n_checked, want.notify, got.notify));
          if (got.restart_timer != want.restart_timer)
            fault($sformatf("result %0d: restart_timer expected %0d, got %0d",
                            n_checked, want.restart_timer, got.restart_timer));
        end
        n_checked++;
      end
    end
    awaited_count  <= awaited_states.size();
    mismatch_count <= errs;
  end

endmodule

// ----- sim/consensus_election_role_fsm_tb.sv -----
// Top-level testbench: clock, reset, event stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps

module consensus_election_role_fsm_tb;
  import cer_pkg::*;

  // The event channel also carries a fourth kind code that the block must ignore.
  localparam logic [1:0] KIND_UNDEFINED = 2'd3;

  // Journal values at their extremes; every negative value means empty or undefined.
  localparam logic [LSN_W-1:0] LSN_EMPTY    = {LSN_W{1'b1}};
  localparam logic [LSN_W-1:0] LSN_MOST_NEG = 33'h1_0000_0000;
  localparam logic [LSN_W-1:0] LSN_TOP      = 33'h0_FFFF_FFFF;

  localparam int RANDOM_PER_PHASE = 321;
  localparam int HOLDOFF_CYCLES   = 200;
  // No correct run goes this long without a beat on either channel: the longest quiet
  // stretch is the receiver hold-off plus drain and register writes.
  localparam int QUIET_LIMIT      = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cer_in_if  event_ch ();
  cer_out_if report_ch ();

  int mismatch_count;
  int awaited_count;

  // Stimulus knobs and bookkeeping.
  int          send_idle_pct = 31;
  int          recv_idle_pct = 73;
  logic        holdoff_req   = 1'b0;
  logic [3:0]  node_self     = '0;
  logic [31:0] seen_term     = '0;
  logic [4:0]  seen_leader   = LEADER_NONE;
  int          kind_seen[4];
  int          n_results;
  int          n_settings = 1;
  int          quiet_cycles;

  always #1 clk = ~clk;

  consensus_election_role_fsm DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (event_ch),
    .out_beat  (report_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  consensus_election_role_fsm_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (event_ch),
    .out_mon        (report_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  // Result receiver. It normally stalls at random, but once the stimulus raises
  // holdoff_req it keeps ready low for a long stretch, counted here, so the block's
  // two registers fill and the event channel sees ready drop.
  initial begin : receiver
    int   holdoff_left;
    logic holdoff_done;
    holdoff_left    = 0;
    holdoff_done    = 1'b0;
    report_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        report_ch.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
        report_ch.ready <= 1'b0;
        holdoff_left--;
      end else if (holdoff_req && !holdoff_done) begin
        report_ch.ready <= 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end else begin
        report_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Follow the reported term and leader, so that random messages mostly carry terms
  // close to the node's own and name the leader it currently knows. That keeps the
  // role machine moving between all four roles instead of being flattened by noise.
  always @(posedge clk) begin
    if (report_ch.valid && report_ch.ready) begin
      seen_term   <= report_ch.cur_term;
      seen_leader <= report_ch.cur_leader;
      n_results   <= n_results + 1;
    end
  end

  // Watchdog: any beat on either channel resets the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (event_ch.valid && event_ch.ready) || (report_ch.valid && report_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles, %0d results still awaited",
                 $time, QUIET_LIMIT, awaited_count);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic item_t make_event(logic [1:0] kind, logic [3:0] from, logic [4:0] lead,
                                       logic [31:0] term, logic [LSN_W-1:0] msg_lsn,
                                       logic [LSN_W-1:0] msg_ct, logic [LSN_W-1:0] own_lsn,
                                       logic [LSN_W-1:0] own_ct, logic missed);
    item_t ev;
    ev.kind             = kind;
    ev.from_id          = from;
    ev.msg_leader       = lead;
    ev.msg_term         = term;
    ev.msg_commit_lsn   = msg_lsn;
    ev.msg_commit_term  = msg_ct;
    ev.own_commit_lsn   = own_lsn;
    ev.own_commit_term  = own_ct;
    ev.heartbeat_missed = missed;
    return ev;
  endfunction

  // Journal numbers: mostly small so that equal and ordered pairs are common, with
  // empty, arbitrary negative and full-scale values mixed in.
  function automatic logic [LSN_W-1:0] random_journal_value();
    case ($urandom_range(0, 9))
      0, 1:    return LSN_EMPTY;
      2:       return {1'b1, 32'($urandom())};
      3:       return LSN_TOP;
      4:       return {1'b0, 32'($urandom())};
      default: return LSN_W'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic item_t random_event();
    item_t ev;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      ev.kind = KIND_VOTE;
    else if (pick < 65) ev.kind = KIND_APPEND;
    else if (pick < 95) ev.kind = KIND_TICK;
    else                ev.kind = KIND_UNDEFINED;

    pick = $urandom_range(0, 99);
    if (pick < 35)      ev.msg_leader = seen_leader;
    else if (pick < 60) ev.msg_leader = {1'b0, node_self};
    else if (pick < 85) ev.msg_leader = 5'($urandom_range(0, 16));
    else                ev.msg_leader = 5'($urandom_range(0, 31));

    // For a named node id, half the time the sender names itself, which is what adopts a new leader.
    if (ev.msg_leader < LEADER_NONE && $urandom_range(0, 1) == 1)
      ev.from_id = ev.msg_leader[3:0];
    else
      ev.from_id = 4'($urandom_range(0, 15));

    case ($urandom_range(0, 9))
      0:       ev.msg_term = $urandom();
      1:       ev.msg_term = '0;
      2:       ev.msg_term = '1;
      default: ev.msg_term = seen_term + 32'($urandom_range(0, 3)) - 32'd1;
    endcase

    ev.msg_commit_lsn   = random_journal_value();
    ev.msg_commit_term  = random_journal_value();
    ev.own_commit_lsn   = random_journal_value();
    ev.own_commit_term  = random_journal_value();
    ev.heartbeat_missed = ($urandom_range(0, 99) < 75);
    return ev;
  endfunction

  // Offer one event beat and hold it until accepted. Idle cycles go in front of the
  // beat, so valid only drops between beats and never inside a step that raises it.
  task automatic send_event(input item_t ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      event_ch.valid <= 1'b0;
      @(posedge clk);
    end
    event_ch.valid            <= 1'b1;
    event_ch.kind             <= ev.kind;
    event_ch.from_id          <= ev.from_id;
    event_ch.msg_leader       <= ev.msg_leader;
    event_ch.msg_term         <= ev.msg_term;
    event_ch.msg_commit_lsn   <= ev.msg_commit_lsn;
    event_ch.msg_commit_term  <= ev.msg_commit_term;
    event_ch.own_commit_lsn   <= ev.own_commit_lsn;
    event_ch.own_commit_term  <= ev.own_commit_term;
    event_ch.heartbeat_missed <= ev.heartbeat_missed;
    do @(posedge clk); while (!event_ch.ready);
    kind_seen[ev.kind]++;
  endtask

  // Stop offering events and wait until every event in flight has reported back.
  task automatic drain();
    event_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  // Write all three registers on consecutive edges; cfg_we drops once at the end.
  task automatic write_settings(input logic [4:0] id_val, input logic [4:0] size_val,
                                input logic [4:0] quorum_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SELF_ID;
    cfg_wdata <= id_val;
    @(posedge clk);
    cfg_index <= CFG_NODE_COUNT;
    cfg_wdata <= size_val;
    @(posedge clk);
    cfg_index <= CFG_QUORUM;
    cfg_wdata <= quorum_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    node_self <= id_val[3:0];
    n_settings++;
  endtask

  initial begin
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_index                 = CFG_SELF_ID;
    cfg_wdata                 = '0;
    event_ch.valid            = 1'b0;
    event_ch.kind             = KIND_VOTE;
    event_ch.from_id          = '0;
    event_ch.msg_leader       = LEADER_NONE;
    event_ch.msg_term         = '0;
    event_ch.msg_commit_lsn   = LSN_EMPTY;
    event_ch.msg_commit_term  = LSN_EMPTY;
    event_ch.own_commit_lsn   = LSN_EMPTY;
    event_ch.own_commit_term  = LSN_EMPTY;
    event_ch.heartbeat_missed = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first with the reset settings: a single-node cluster with self id 0.
    // The node starts as a follower with term zero and no leader.
    send_event(make_event(KIND_TICK, 4'd0, 5'd0, 32'd0, 33'd0, 33'd0, 33'd0, 33'd0, 1'b0));
    send_event(make_event(KIND_UNDEFINED, 4'd9, 5'd3, 32'd77, 33'd1, 33'd2, 33'd3, 33'd4,
                          1'b1));
    // A leader code above the none value is taken as none, which matches the known leader.
    send_event(make_event(KIND_VOTE, 4'd2, 5'd20, 32'd0, 33'd5, 33'd0, 33'd5, 33'd0, 1'b0));
    // Same term but our journal is empty: the vote request does not win.
    send_event(make_event(KIND_VOTE, 4'd2, 5'd2, 32'd0, 33'd5, 33'd0, LSN_EMPTY, 33'd0,
                          1'b0));
    // Same term, equal journals: the request wins and the node enters election.
    send_event(make_event(KIND_VOTE, 4'd2, 5'd2, 32'd0, 33'd4, 33'd0, 33'd4, 33'd0, 1'b0));
    send_event(make_event(KIND_APPEND, 4'd7, 5'd7, 32'd0, 33'd0, 33'd0, 33'd0, 33'd0, 1'b0));
    send_event(make_event(KIND_APPEND, 4'd7, LEADER_NONE, 32'hFFFF_FFFF, LSN_TOP, LSN_TOP,
                          LSN_TOP, LSN_TOP, 1'b0));
    // A single-node follower that misses a heartbeat leads at once; the term wraps to zero.
    send_event(make_event(KIND_TICK, 4'd0, 5'd0, 32'd0, 33'd0, 33'd0, 33'd0, 33'd0, 1'b1));
    // A tick to a leader changes nothing.
    send_event(make_event(KIND_TICK, 4'd0, 5'd0, 32'd0, 33'd0, 33'd0, 33'd0, 33'd0, 1'b1));
    // Two undefined commit terms compare equal, so the leader stays.
    send_event(make_event(KIND_APPEND, 4'd4, 5'd4, 32'd0, 33'd0, LSN_MOST_NEG, 33'd0,
                          LSN_EMPTY, 1'b0));
    // A defined commit term beats an undefined one and demotes the leader.
    send_event(make_event(KIND_APPEND, 4'd4, 5'd4, 32'd0, 33'd0, 33'd5, 33'd0, LSN_EMPTY,
                          1'b0));
    send_event(make_event(KIND_VOTE, 4'd4, 5'd4, 32'd0, 33'd0, 33'd0, 33'd0, 33'd0, 1'b0));

    // Three nodes, two votes to win, self id 15: walk through candidacy and its rounds.
    drain();
    write_settings(5'd15, 5'd3, 5'd2);
    send_event(make_event(KIND_TICK, 4'd0, 5'd0, 32'd0, 33'd0, 33'd0, 33'd0, 33'd0, 1'b1));
    send_event(make_event(KIND_VOTE, 4'd3, 5'd15, 32'd1, 33'd0, 33'd0, 33'd0, 33'd0, 1'b0));
    send_event(make_event(KIND_VOTE, 4'd1, 5'd1, 32'd10, 33'd0, 33'd0, 33'd0, 33'd0, 1'b0));
    repeat (6) begin
      // Election to candidate, then repeated rounds until the round count caps at five.
      send_event(make_event(KIND_TICK, 4'd0, 5'd0, 32'd0, 33'd0, 33'd0, 33'd0, 33'd0, 1'b1));
    end
    send_event(make_event(KIND_APPEND, 4'd6, 5'd6, 32'd20, 33'd0, 33'd0, 33'd0, 33'd0, 1'b0));
    send_event(make_event(KIND_VOTE, 4'd6, LEADER_NONE, 32'h8000_0000, 33'd9, 33'd0, 33'd2,
                          33'd0, 1'b0));
    send_event(make_event(KIND_UNDEFINED, 4'hF, 5'h1F, 32'hFFFF_FFFF, LSN_TOP, LSN_EMPTY,
                          LSN_MOST_NEG, LSN_TOP, 1'b1));

    // Random phases. Each starts from an idle block with fresh settings, including a
    // zero-sized cluster with a zero quorum, a quorum above the cluster size, a full
    // sixteen-node cluster and register data with the unused upper bit set.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0:       write_settings(5'd3, 5'd5, 5'd3);
        1:       write_settings(5'd15, 5'd16, 5'd16);
        2:       write_settings(5'd0, 5'd1, 5'd1);
        3:       write_settings(5'd9, 5'd0, 5'd0);
        4:       write_settings(5'd6, 5'd3, 5'd7);
        default: write_settings(5'd26, 5'd31, 5'd2);
      endcase
      // Sender-light/receiver-heavy idling first, then the reverse, then none at all.
      if (ph < 2) begin
        send_idle_pct <= 31;
        recv_idle_pct <= 73;
      end else if (ph < 4) begin
        send_idle_pct <= 73;
        recv_idle_pct <= 31;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (ph == 1 && k == 60) holdoff_req <= 1'b1;
        if (ph == 2 && k == 150) drain();
        send_event(random_event());
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d events (%0d vote, %0d append-entries, %0d tick, %0d undefined)",
             kind_seen[0] + kind_seen[1] + kind_seen[2] + kind_seen[3],
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("under %0d register settings; %0d result beats compared, %0d mismatches.",
             n_settings, n_results, mismatch_count);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
